// ===== hdl/wvs_pkg.sv =====
// ============================================================================
// wvs_pkg: shared definitions for the windowed vertical speed unit
// Widths, constants, sequencer states and the control and status bundles
// that pass between the sequencer and the datapath.
// ============================================================================
package wvs_pkg;

    // Number of samples in the sliding window (2..64).
    localparam int WINDOW    = 8;

    // Field widths.
    localparam int ALT_W     = 20;
    localparam int MS_W      = 10;
    localparam int VS_W      = 21;

    // Timestamp wrap and feet-per-minute scale (60 s * 1000 ms).
    localparam int MS_WRAP   = 1000;
    localparam int FPM_W     = 16;
    localparam logic [FPM_W-1:0] FPM_SCALE = FPM_W'(60 * 1000);

    // Storage and arithmetic widths derived from the window.
    localparam int PTR_W     = $clog2(WINDOW);
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int TOTAL_W   = $clog2((WINDOW - 1) * (MS_WRAP - 1) + 1);
    localparam int MAG_W     = $clog2(((64'd1 << ALT_W) * 64'd60000) + 64'd1);
    localparam int ENTRY_W   = ALT_W + MS_W;
    localparam int CNT_MAX   = (WINDOW > MAG_W) ? WINDOW : MAG_W;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } wvs_state_t;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic scan_first;
        logic scan_gap;
        logic mul;
        logic div_step;
        logic take;
    } wvs_ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic will_full;
        logic total_zero;
    } wvs_stat_t;

    // Advance a window pointer with wrap at the window depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== hdl/wvs_ctrl.sv =====
// ============================================================================
// wvs_ctrl: sequencer for the windowed vertical speed unit
// Walks one sample through the window scan, the scaling multiply, the
// bit-serial division and the hand-off to the output register.
// ============================================================================
module wvs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_free,
    input  wvs_pkg::wvs_stat_t  stat,
    output logic                in_ready,
    output wvs_pkg::wvs_ctrl_t  ctrl
);

    wvs_pkg::wvs_state_t              state_reg;
    wvs_pkg::wvs_state_t              state_next;
    logic [wvs_pkg::CNT_W-1:0]        cnt_reg;
    logic [wvs_pkg::CNT_W-1:0]        cnt_next;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wvs_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wvs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.will_full ? wvs_pkg::ST_SCAN : wvs_pkg::ST_DONE;
                end
            end
            wvs_pkg::ST_SCAN:
            begin
                if (cnt_reg == wvs_pkg::CNT_W'(wvs_pkg::WINDOW))
                begin
                    state_next = wvs_pkg::ST_MUL;
                end
            end
            wvs_pkg::ST_MUL:
            begin
                state_next = stat.total_zero ? wvs_pkg::ST_DONE : wvs_pkg::ST_DIV;
            end
            wvs_pkg::ST_DIV:
            begin
                if (cnt_reg == wvs_pkg::CNT_W'(wvs_pkg::MAG_W - 1))
                begin
                    state_next = wvs_pkg::ST_DONE;
                end
            end
            wvs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = wvs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wvs_pkg::ST_IDLE;
            end
        endcase
    end

    // The counter runs while the scan or the division stays in its state.
    always_comb
    begin
        cnt_next = '0;
        if ((state_reg == state_next) &&
            ((state_reg == wvs_pkg::ST_SCAN) || (state_reg == wvs_pkg::ST_DIV)))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Outputs.
    always_comb
    begin
        in_ready        = 1'b0;
        ctrl            = '0;
        case (state_reg)
            wvs_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            wvs_pkg::ST_SCAN:
            begin
                ctrl.scan_first = (cnt_reg == wvs_pkg::CNT_W'(1));
                ctrl.scan_gap   = (cnt_reg >= wvs_pkg::CNT_W'(2));
            end
            wvs_pkg::ST_MUL:
            begin
                ctrl.mul = 1'b1;
            end
            wvs_pkg::ST_DIV:
            begin
                ctrl.div_step = 1'b1;
            end
            wvs_pkg::ST_DONE:
            begin
                ctrl.take = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// ===== hdl/wvs_datapath.sv =====
// ============================================================================
// wvs_datapath: sample window and arithmetic for the vertical speed unit
// Holds the sample window as a circular memory, sums the timestamp gaps one
// entry a cycle, scales the altitude change and divides one bit a cycle.
// ============================================================================
module wvs_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wvs_pkg::wvs_ctrl_t               ctrl,
    input  logic signed [wvs_pkg::ALT_W-1:0] altitude_ft,
    input  logic [wvs_pkg::MS_W-1:0]         millis,
    output wvs_pkg::wvs_stat_t               stat,
    output logic signed [wvs_pkg::VS_W-1:0]  res_speed,
    output logic                             res_full
);

    localparam logic signed [wvs_pkg::MS_W+1:0] WRAP_S = (wvs_pkg::MS_W + 2)'(wvs_pkg::MS_WRAP);
    localparam logic [wvs_pkg::MAG_W-1:0] POS_LIMIT = wvs_pkg::MAG_W'((1 << (wvs_pkg::VS_W - 1)) - 1);
    localparam logic [wvs_pkg::MAG_W-1:0] NEG_LIMIT = wvs_pkg::MAG_W'(1 << (wvs_pkg::VS_W - 1));

    // Sample window memory and its pointers.
    logic [wvs_pkg::ENTRY_W-1:0]      mem [wvs_pkg::WINDOW];
    logic [wvs_pkg::ENTRY_W-1:0]      rd_data_reg;
    logic [wvs_pkg::PTR_W-1:0]        wr_ptr_reg;
    logic [wvs_pkg::PTR_W-1:0]        wr_ptr_next;
    logic [wvs_pkg::PTR_W-1:0]        rd_ptr_reg;
    logic [wvs_pkg::FILL_W-1:0]       fill_reg;

    // Working registers.
    logic signed [wvs_pkg::ALT_W-1:0] alt_new_reg;
    logic signed [wvs_pkg::ALT_W-1:0] alt_old_reg;
    logic [wvs_pkg::MS_W-1:0]         prev_ms_reg;
    logic [wvs_pkg::TOTAL_W-1:0]      total_reg;
    logic                             full_reg;
    logic                             neg_reg;
    logic [wvs_pkg::TOTAL_W:0]        rem_reg;
    logic [wvs_pkg::MAG_W-1:0]        quo_reg;

    // Arithmetic nets.
    logic [wvs_pkg::MS_W-1:0]         rd_ms;
    logic signed [wvs_pkg::ALT_W-1:0] rd_alt;
    logic [wvs_pkg::MS_W-1:0]         gap;
    logic signed [wvs_pkg::ALT_W:0]   diff;
    logic [wvs_pkg::ALT_W:0]          mag;
    logic [wvs_pkg::ALT_W+wvs_pkg::FPM_W:0] product;
    logic [wvs_pkg::TOTAL_W:0]        rem_sh;
    logic [wvs_pkg::TOTAL_W+1:0]      trial;
    logic                             fits;

    // Gap from older to newer timestamp, reduced to 0..999.
    function automatic logic [wvs_pkg::MS_W-1:0] gap_ms(
        input logic [wvs_pkg::MS_W-1:0] newer,
        input logic [wvs_pkg::MS_W-1:0] older
    );
        logic signed [wvs_pkg::MS_W+1:0] t;
        t = $signed({2'b00, newer}) - $signed({2'b00, older}) + WRAP_S;
        if (t < 0)
        begin
            t = t + WRAP_S;
        end
        else if (t >= (WRAP_S <<< 1))
        begin
            t = t - (WRAP_S <<< 1);
        end
        else if (t >= WRAP_S)
        begin
            t = t - WRAP_S;
        end
        return t[wvs_pkg::MS_W-1:0];
    endfunction

    assign wr_ptr_next = wvs_pkg::ptr_inc(wr_ptr_reg);
    assign rd_alt      = rd_data_reg[wvs_pkg::ENTRY_W-1:wvs_pkg::MS_W];
    assign rd_ms       = rd_data_reg[wvs_pkg::MS_W-1:0];
    assign gap         = gap_ms(rd_ms, prev_ms_reg);

    // Altitude change and its scaled magnitude.
    assign diff    = {alt_new_reg[wvs_pkg::ALT_W-1], alt_new_reg}
                   - {alt_old_reg[wvs_pkg::ALT_W-1], alt_old_reg};
    assign mag     = diff[wvs_pkg::ALT_W] ? $unsigned(-diff) : $unsigned(diff);
    assign product = mag * wvs_pkg::FPM_SCALE;

    // One restoring division step.
    assign rem_sh = {rem_reg[wvs_pkg::TOTAL_W-1:0], quo_reg[wvs_pkg::MAG_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, total_reg};
    assign fits   = !trial[wvs_pkg::TOTAL_W+1];

    assign stat.will_full  = (fill_reg >= wvs_pkg::FILL_W'(wvs_pkg::WINDOW - 1));
    assign stat.total_zero = (total_reg == '0);

    // Window memory: written on each accepted beat, read one entry a cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mem[wr_ptr_reg] <= {altitude_ft, millis};
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

    // Window pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= wr_ptr_next;
                if (fill_reg != wvs_pkg::FILL_W'(wvs_pkg::WINDOW))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else
            begin
                rd_ptr_reg <= wvs_pkg::ptr_inc(rd_ptr_reg);
            end
        end
    end

    // Scan, multiply and divide registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            alt_new_reg <= altitude_ft;
            full_reg    <= stat.will_full;
            total_reg   <= '0;
        end
        if (ctrl.scan_first)
        begin
            alt_old_reg <= rd_alt;
            prev_ms_reg <= rd_ms;
        end
        if (ctrl.scan_gap)
        begin
            total_reg   <= total_reg + wvs_pkg::TOTAL_W'(gap);
            prev_ms_reg <= rd_ms;
        end
        if (ctrl.mul)
        begin
            neg_reg <= diff[wvs_pkg::ALT_W];
            quo_reg <= product[wvs_pkg::MAG_W-1:0];
            rem_reg <= '0;
        end
        if (ctrl.div_step)
        begin
            rem_reg <= fits ? trial[wvs_pkg::TOTAL_W:0] : rem_sh;
            quo_reg <= {quo_reg[wvs_pkg::MAG_W-2:0], fits};
        end
    end

    // Signed, saturated result from the quotient.
    always_comb
    begin
        res_full  = full_reg;
        res_speed = '0;
        if (full_reg && !stat.total_zero)
        begin
            if (neg_reg)
            begin
                res_speed = (quo_reg > NEG_LIMIT) ? NEG_LIMIT[wvs_pkg::VS_W-1:0]
                                                  : '0 - quo_reg[wvs_pkg::VS_W-1:0];
            end
            else
            begin
                res_speed = (quo_reg > POS_LIMIT) ? POS_LIMIT[wvs_pkg::VS_W-1:0]
                                                  : quo_reg[wvs_pkg::VS_W-1:0];
            end
        end
    end

endmodule

// ===== hdl/windowed_vertical_speed_unit.sv =====
// ============================================================================
// windowed_vertical_speed_unit: feet-per-minute rate over a sample window
// Top level: sequencer, datapath and the output register.
// ============================================================================
// Each input beat carries one altitude sample and its millisecond stamp. The
// first WINDOW-1 beats, while the window fills, each give a zero result with
// window_full low. From then on every beat gives 60000 * (newest - oldest
// altitude) / (sum of wrapped stamp gaps), truncated toward zero and saturated
// to 21 bits, or zero when the gaps sum to zero. The next beat is taken only
// once the last is handed off. A full-window beat walks the window memory one
// entry a cycle, does the scaling multiply, runs the one-bit-per-cycle
// restoring divider unless the gaps sum to zero, and waits for the output
// register to be free before the hand-off. A new beat is taken while an
// earlier result still waits in the output register.
module windowed_vertical_speed_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [wvs_pkg::ALT_W-1:0] altitude_ft,
    input  logic [wvs_pkg::MS_W-1:0]         millis,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [wvs_pkg::VS_W-1:0]  vertical_speed,
    output logic                             window_full
);

    wvs_pkg::wvs_ctrl_t               ctrl;
    wvs_pkg::wvs_stat_t               stat;
    logic                             out_free;
    logic signed [wvs_pkg::VS_W-1:0]  res_speed;
    logic                             res_full;
    logic                             out_valid_reg;
    logic signed [wvs_pkg::VS_W-1:0]  speed_reg;
    logic                             full_out_reg;

    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign vertical_speed = speed_reg;
    assign window_full    = full_out_reg;

    wvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    wvs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .altitude_ft (altitude_ft),
        .millis      (millis),
        .stat        (stat),
        .res_speed   (res_speed),
        .res_full    (res_full)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            speed_reg    <= res_speed;
            full_out_reg <= res_full;
        end
    end

`ifndef SYNTHESIS
    // An accepted beat keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken on two cycles in a row");

    // A result before the window is full is always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !window_full) |-> (vertical_speed == '0))
        else $error("nonzero speed while window not full");

    // The divider never runs against a zero time sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_step |-> !stat.total_zero)
        else $error("division started with zero time sum");

    // A handed-off result shows up as a valid output beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.take |=> out_valid)
        else $error("result hand-off lost");
`endif

endmodule
